@@ rtl/text_console_scroll_writer_unit_defines.svh @@
// Assertion macros used by the text console scroll writer core.
`ifndef TEXT_CONSOLE_SCROLL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Whenever cond holds, prop holds in the same cycle.
`define TCSW_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tcsw assertion failed");

// Whenever cond holds, prop holds in the next cycle.
`define TCSW_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tcsw assertion failed");

`else

`define TCSW_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define TCSW_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

@@ rtl/tcsw_pkg.sv @@
// Types and constants of the text console scroll writer.
package tcsw_pkg;

   localparam int ADDR_WIDTH = 11;
   localparam int CHAR_WIDTH = 8;

   localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'd13;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF      = 8'd10;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] ATTR_RESET   = 8'h07;
   localparam logic [CHAR_WIDTH-1:0] ATTR_CLEAR   = 8'h00;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [ADDR_WIDTH-1:0]     address;
      logic [CHAR_WIDTH-1:0]     character;
      logic [CHAR_WIDTH-1:0]     attribute;
      logic [ADDR_WIDTH-1:0]     display_start;
      logic                      last;
   } cmd_type;

endpackage

@@ rtl/tcsw_in_stage.sv @@
// Input register with skid entry for the character channel.
module tcsw_in_stage
   import tcsw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_WIDTH-1:0] req_character,
   output logic                  item_valid,
   output logic [CHAR_WIDTH-1:0] item_character,
   input  logic                  item_take
);

   logic                  main_valid_ff, main_valid_in;
   logic [CHAR_WIDTH-1:0] main_char_ff, main_char_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [CHAR_WIDTH-1:0] skid_char_ff, skid_char_in;
   logic                  accept;

   assign req_stall      = skid_valid_ff;
   assign accept         = req_valid && !skid_valid_ff;
   assign item_valid     = main_valid_ff;
   assign item_character = main_char_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_char_in  = main_char_ff;
      skid_valid_in = skid_valid_ff;
      skid_char_in  = skid_char_ff;
      if (item_take) begin
         if (skid_valid_ff) begin
            main_char_in  = skid_char_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_char_in  = req_character;
         end else begin
            skid_valid_in = 1'b1;
            skid_char_in  = req_character;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_char_ff <= main_char_in;
      skid_char_ff <= skid_char_in;
   end

endmodule

@@ rtl/tcsw_core.sv @@
// Cursor, row base and start address state; builds one command per cycle while not stalled.
`include "text_console_scroll_writer_unit_defines.svh"

module tcsw_core
   import tcsw_pkg::*;
#(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 24,
   parameter int RAM_CELLS = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CHAR_WIDTH-1:0] csr_write_data,
   input  logic                  item_valid,
   input  logic [CHAR_WIDTH-1:0] item_character,
   output logic                  item_take,
   input  logic                  out_ready,
   output logic                  cmd_valid,
   output cmd_type               cmd
);

   localparam int AW = $clog2(RAM_CELLS);
   localparam int RW = $clog2(ROWS + 1);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [AW:0]   RAM_W    = (AW+1)'(RAM_CELLS);
   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
   localparam logic [RW-1:0] ROW_FULL = RW'(ROWS);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

   // row_base tracks (start + COLUMNS*row) mod RAM_CELLS
   logic [RW-1:0]         row_ff, row_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [AW-1:0]         start_ff, start_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [CHAR_WIDTH-1:0] attr_ff;
   logic                  is_cr, is_lf, is_print, scroll;
   logic [AW-1:0]         wr_addr, base_next, start_next;
   logic                  clear_first;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= RAM_W) s = s - RAM_W;
      return s[AW-1:0];
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] to_port(input logic [AW-1:0] a);
      logic [AW+ADDR_WIDTH-1:0] e;
      e = {{ADDR_WIDTH{1'b0}}, a};
      return e[ADDR_WIDTH-1:0];
   endfunction

   assign is_cr      = item_character == CHAR_CR;
   assign is_lf      = item_character == CHAR_LF;
   assign is_print   = !is_cr && !is_lf;
   assign scroll     = row_ff == ROW_FULL;
   assign wr_addr    = wrap_add(base_ff, {{(AW-CW){1'b0}}, col_ff});
   assign base_next  = wrap_add(base_ff, COLS_A);
   assign start_next = wrap_add(start_ff, COLS_A);

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      start_in  = start_ff;
      base_in   = base_ff;
      item_take = 1'b0;
      cmd_valid = 1'b0;
      cmd.kind          = CMD_WRITE;
      cmd.address       = to_port(wr_addr);
      cmd.character     = item_character;
      cmd.attribute     = attr_ff;
      cmd.display_start = to_port(start_ff);
      cmd.last          = 1'b1;
      if (item_valid) begin
         if (scroll) begin
            // clear row sits at the current row base; base stays put unless the character is LF
            if (out_ready) begin
               cmd_valid         = 1'b1;
               cmd.kind          = CMD_CLEAR;
               cmd.address       = to_port(base_ff);
               cmd.character     = CHAR_SPACE;
               cmd.attribute     = ATTR_CLEAR;
               cmd.display_start = to_port(start_next);
               cmd.last          = !is_print;
               start_in          = start_next;
               row_in            = ROW_LAST;
               if (is_cr) begin
                  col_in    = '0;
                  item_take = 1'b1;
               end else if (is_lf) begin
                  col_in    = '0;
                  row_in    = ROW_FULL;
                  base_in   = base_next;
                  item_take = 1'b1;
               end
            end
         end else if (is_cr) begin
            col_in    = '0;
            item_take = 1'b1;
         end else if (is_lf) begin
            col_in    = '0;
            row_in    = row_ff + RW'(1);
            base_in   = base_next;
            item_take = 1'b1;
         end else if (out_ready) begin
            cmd_valid = 1'b1;
            item_take = 1'b1;
            if (col_ff == COL_LAST) begin
               col_in  = '0;
               row_in  = row_ff + RW'(1);
               base_in = base_next;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         start_ff <= '0;
         base_ff  <= '0;
         attr_ff  <= ATTR_RESET;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         base_ff  <= base_in;
         if (csr_write_enable) attr_ff <= csr_write_data;
      end
   end

   // a row clear that leaves its printable character for the next cycle
   assign clear_first = cmd_valid && (cmd.kind == CMD_CLEAR) && !cmd.last;

   `TCSW_ASSERT_IMPLIES(a_row_range, clock, reset, 1'b1, row_ff <= ROW_FULL)
   `TCSW_ASSERT_IMPLIES(a_col_range, clock, reset, 1'b1, col_ff <= COL_LAST)
   `TCSW_ASSERT_IMPLIES(a_start_range, clock, reset, 1'b1, ({1'b0, start_ff} < RAM_W))
   `TCSW_ASSERT_IMPLIES(a_base_range, clock, reset, 1'b1, ({1'b0, base_ff} < RAM_W))
   `TCSW_ASSERT_NEXT(a_clear_then_write, clock, reset, clear_first, item_valid && (row_ff == ROW_LAST))

endmodule

@@ rtl/text_console_scroll_writer_unit.sv @@
// Top level of the text console scroll writer: input stage, core, result register.
//
//   channel  | direction | handshake             | payload
//   req_     | in        | req_valid / req_stall | req_character
//   rsp_     | out       | rsp_valid / rsp_stall | command kind, address, char, attr, start, last
//   csr_     | in        | csr_write_enable      | csr_write_data (text attribute)
//
// A printable character is taken from the input register with its write, after a row
// clear when one precedes it; CR and LF without a scroll emit nothing.
// A result passes through the input register, then the result register; a write
// behind a row clear follows that clear. reset is synchronous, active high, and
// clears cursor, start address and attribute (to 7). rsp_stall holds the result
// register; the skid entry keeps req_stall a registered signal.
module text_console_scroll_writer_unit
   import tcsw_pkg::*;
#(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 24,
   parameter int RAM_CELLS = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CHAR_WIDTH-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_WIDTH-1:0] req_character,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_command_kind,
   output logic [ADDR_WIDTH-1:0] rsp_cell_address,
   output logic [CHAR_WIDTH-1:0] rsp_cell_character,
   output logic [CHAR_WIDTH-1:0] rsp_cell_attribute,
   output logic [ADDR_WIDTH-1:0] rsp_display_start,
   output logic                  rsp_last_of_run
);

   logic                  item_valid;
   logic [CHAR_WIDTH-1:0] item_character;
   logic                  item_take;
   logic                  out_ready;
   logic                  cmd_valid;
   cmd_type               cmd;
   logic                  rsp_valid_ff, rsp_valid_in;
   cmd_type               rsp_cmd_ff;

   tcsw_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .item_valid     (item_valid),
      .item_character (item_character),
      .item_take      (item_take)
   );

   tcsw_core #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .RAM_CELLS (RAM_CELLS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item_character   (item_character),
      .item_take        (item_take),
      .out_ready        (out_ready),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_valid) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd_valid) rsp_cmd_ff <= cmd;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command_kind   = rsp_cmd_ff.kind;
   assign rsp_cell_address   = rsp_cmd_ff.address;
   assign rsp_cell_character = rsp_cmd_ff.character;
   assign rsp_cell_attribute = rsp_cmd_ff.attribute;
   assign rsp_display_start  = rsp_cmd_ff.display_start;
   assign rsp_last_of_run    = rsp_cmd_ff.last;

endmodule
